/* hdl/scm_pkg.sv */
package scm_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int SWITCH_COUNT = 6;
    localparam int SWITCH_W     = 6;
    localparam int AXES         = 4;
    localparam int AXIS_W       = 2;
    localparam int CHAN_W       = 11;
    localparam int SPAN_W       = 11;
    localparam int PROD_W       = SAMPLE_W + SPAN_W;
    localparam int QUO_W        = 12;
    localparam int CNT_W        = 4;
    localparam int VAL_W        = 14;
    localparam int INV_W        = 10;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [SAMPLE_W-1:0] RESET_POINT = 16'd500;
    localparam logic [CHAN_W-1:0]   CHAN_LOW_RST  = 11'd204;
    localparam logic [CHAN_W-1:0]   CHAN_HIGH_RST = 11'd1844;
    localparam logic [INV_W-1:0]    INVERT_RST    = 10'd1;

    // floor(x / 3) == (x * 43691) >> 17 for every 16-bit x
    localparam logic [16:0] THIRD_RECIP = 17'd43691;
    localparam int          THIRD_SHIFT = 17;

    localparam logic [1:0] FUNC_CAL = 2'd0;
    localparam logic [1:0] FUNC_FLY = 2'd1;

    localparam logic [1:0] REG_INVERT    = 2'd0;
    localparam logic [1:0] REG_CHAN_LOW  = 2'd1;
    localparam logic [1:0] REG_CHAN_HIGH = 2'd2;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_WIDEN = 9'b000000010,
        ST_THIRD = 9'b000000100,
        ST_FLAGS = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_SAT   = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_FIX   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

endpackage

/* hdl/stick_calibrate_and_map_top.sv */
// Per axis, calibrate/observe items run widen, third and flags; fly items then add multiply,
// range check, 12 divide steps (skipped on zero range or saturation) and fix.
// Flow: one item at a time; in_stall stays high until the result enters the output register,
// which waits while out_stall holds the previous result.
// The divide loop retires one quotient bit per cycle.
// Reset: rst_n asynchronous active low; axis ranges return to 500/500, registers to defaults.
module stick_calibrate_and_map_top
    import scm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [SAMPLE_W-1:0] throttle_sample,
    input  logic [SAMPLE_W-1:0] yaw_sample,
    input  logic [SAMPLE_W-1:0] roll_sample,
    input  logic [SAMPLE_W-1:0] pitch_sample,
    input  logic [SWITCH_W-1:0] switch_bits,
    input  logic                menu_button,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                channels_valid,
    output logic [CHAN_W-1:0]   throttle_channel,
    output logic [CHAN_W-1:0]   yaw_channel,
    output logic [CHAN_W-1:0]   roll_channel,
    output logic [CHAN_W-1:0]   pitch_channel,
    output logic [SWITCH_W-1:0] switch_high_mask,
    output logic                menu_pressed,
    output logic                range_changed,
    output logic                sticks_centered,
    output logic [AXES-1:0]     up_flags,
    output logic [AXES-1:0]     down_flags
);

    // control and state
    state_t                state_reg, state_next;
    logic [AXIS_W-1:0]     axis_reg, axis_next;
    logic [SAMPLE_W-1:0]   low_reg [AXES];
    logic [SAMPLE_W-1:0]   low_next [AXES];
    logic [SAMPLE_W-1:0]   high_reg [AXES];
    logic [SAMPLE_W-1:0]   high_next [AXES];
    logic                  out_valid_reg, out_valid_next;
    logic [INV_W-1:0]      invert_reg, invert_next;
    logic [CHAN_W-1:0]     chlow_reg, chlow_next;
    logic [CHAN_W-1:0]     chhigh_reg, chhigh_next;

    // item datapath
    logic [1:0]            func_reg, func_next;
    logic [SAMPLE_W-1:0]   smp_reg [AXES];
    logic [SAMPLE_W-1:0]   smp_next [AXES];
    logic [SWITCH_W-1:0]   sw_reg, sw_next;
    logic                  menu_reg, menu_next;
    logic [SAMPLE_W-1:0]   third_reg, third_next;
    logic                  changed_reg, changed_next;
    logic                  centered_reg, centered_next;
    logic [AXES-1:0]       up_reg, up_next;
    logic [AXES-1:0]       down_reg, down_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  neg_reg, neg_next;
    logic [PROD_W-1:0]     rem_reg, rem_next;
    logic [PROD_W-1:0]     dsh_reg, dsh_next;
    logic [QUO_W-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CHAN_W-1:0]     chan_reg [AXES];
    logic [CHAN_W-1:0]     chan_next [AXES];

    // output register
    logic                  o_chv_reg, o_chv_next;
    logic [CHAN_W-1:0]     o_chan_reg [AXES];
    logic [CHAN_W-1:0]     o_chan_next [AXES];
    logic [SWITCH_W-1:0]   o_sw_reg, o_sw_next;
    logic                  o_menu_reg, o_menu_next;
    logic                  o_changed_reg, o_changed_next;
    logic                  o_centered_reg, o_centered_next;
    logic [AXES-1:0]       o_up_reg, o_up_next;
    logic [AXES-1:0]       o_down_reg, o_down_next;

    // shared per-axis arithmetic
    logic [SAMPLE_W-1:0]   cur_s, cur_lo, cur_hi, range_w;
    logic [32:0]           third_prod;
    logic [SAMPLE_W:0]     lo_plus_third, mid, mid_plus, s_plus;
    logic [SAMPLE_W-1:0]   delta;
    logic [AXES-1:0]       inv_axes;
    logic [CHAN_W-1:0]     start_v, end_v, floor_v, ceil_v;
    logic                  s_below, span_neg;
    logic [SAMPLE_W-1:0]   mag_s;
    logic [SPAN_W-1:0]     mag_span;
    logic [PROD_W:0]       sat_lim;
    logic [VAL_W-1:0]      val;
    logic [CHAN_W-1:0]     clamped;
    logic                  in_xfer, out_xfer, cfg_wr, last_axis;
    logic [SWITCH_W-1:0]   sw_map;

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign last_axis = (axis_reg == AXIS_W'(AXES - 1));
    assign in_stall  = (state_reg != ST_IDLE);
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_INVERT:    prdata = DATA_W'(invert_reg);
            REG_CHAN_LOW:  prdata = DATA_W'(chlow_reg);
            REG_CHAN_HIGH: prdata = DATA_W'(chhigh_reg);
            default:       prdata = '0;
        endcase
    end

    // per-axis operands
    assign cur_s      = smp_reg[axis_reg];
    assign cur_lo     = low_reg[axis_reg];
    assign cur_hi     = high_reg[axis_reg];
    assign range_w    = cur_hi - cur_lo;
    assign third_prod = range_w * THIRD_RECIP;
    assign delta      = range_w >> 4;
    assign mid        = {1'b0, cur_lo} + {2'b0, range_w[SAMPLE_W-1:1]};
    assign mid_plus   = mid + {1'b0, delta};
    assign s_plus     = {1'b0, cur_s} + {1'b0, delta};
    assign lo_plus_third = {1'b0, cur_lo} + {1'b0, third_reg};

    assign inv_axes = invert_reg[AXES-1:0];
    assign start_v  = inv_axes[axis_reg] ? chhigh_reg : chlow_reg;
    assign end_v    = inv_axes[axis_reg] ? chlow_reg : chhigh_reg;
    assign floor_v  = (chlow_reg < chhigh_reg) ? chlow_reg : chhigh_reg;
    assign ceil_v   = (chlow_reg < chhigh_reg) ? chhigh_reg : chlow_reg;
    assign s_below  = cur_s < cur_lo;
    assign mag_s    = s_below ? (cur_lo - cur_s) : (cur_s - cur_lo);
    assign span_neg = end_v < start_v;
    assign mag_span = span_neg ? (start_v - end_v) : (end_v - start_v);
    assign sat_lim  = {range_w, {QUO_W{1'b0}}};

    // truncating divide: apply sign to magnitude quotient, then clamp
    assign val = neg_reg ? (VAL_W'(start_v) - VAL_W'(quo_reg))
                         : (VAL_W'(start_v) + VAL_W'(quo_reg));

    always_comb
    begin
        if ($signed(val) < $signed(VAL_W'(floor_v)))
            clamped = floor_v;
        else if ($signed(val) > $signed(VAL_W'(ceil_v)))
            clamped = ceil_v;
        else
            clamped = val[CHAN_W-1:0];
    end

    always_comb
    begin
        sw_map = '0;
        for (int i = 0; i < SWITCH_COUNT; i++)
            sw_map[i] = sw_reg[i] ^ invert_reg[AXES + i];
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        invert_next    = invert_reg;
        chlow_next     = chlow_reg;
        chhigh_next    = chhigh_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        func_next      = func_reg;
        smp_next       = smp_reg;
        sw_next        = sw_reg;
        menu_next      = menu_reg;
        third_next     = third_reg;
        changed_next   = changed_reg;
        centered_next  = centered_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        chan_next      = chan_reg;
        o_chv_next      = o_chv_reg;
        o_chan_next     = o_chan_reg;
        o_sw_next       = o_sw_reg;
        o_menu_next     = o_menu_reg;
        o_changed_next  = o_changed_reg;
        o_centered_next = o_centered_reg;
        o_up_next       = o_up_reg;
        o_down_next     = o_down_reg;

        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_INVERT:    invert_next = pwdata[INV_W-1:0];
                REG_CHAN_LOW:  chlow_next  = pwdata[CHAN_W-1:0];
                REG_CHAN_HIGH: chhigh_next = pwdata[CHAN_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    func_next     = func;
                    smp_next[0]   = throttle_sample;
                    smp_next[1]   = yaw_sample;
                    smp_next[2]   = roll_sample;
                    smp_next[3]   = pitch_sample;
                    sw_next       = switch_bits;
                    menu_next     = menu_button;
                    axis_next     = '0;
                    changed_next  = 1'b0;
                    centered_next = 1'b1;
                    up_next       = '0;
                    down_next     = '0;
                    for (int a = 0; a < AXES; a++)
                        chan_next[a] = '0;
                    state_next    = ST_WIDEN;
                end
            end
            ST_WIDEN:
            begin
                if (func_reg == FUNC_CAL)
                begin
                    if (cur_lo > cur_s)
                    begin
                        low_next[axis_reg] = cur_s;
                        changed_next = 1'b1;
                    end
                    else if (cur_hi < cur_s)
                    begin
                        high_next[axis_reg] = cur_s;
                        changed_next = 1'b1;
                    end
                end
                state_next = ST_THIRD;
            end
            ST_THIRD:
            begin
                third_next = third_prod[THIRD_SHIFT +: SAMPLE_W];
                state_next = ST_FLAGS;
            end
            ST_FLAGS:
            begin
                up_next[axis_reg]   = cur_s > (cur_hi - third_reg);
                down_next[axis_reg] = {1'b0, cur_s} < lo_plus_third;
                if (s_plus < mid || {1'b0, cur_s} > mid_plus)
                    centered_next = 1'b0;
                if (func_reg == FUNC_FLY)
                    state_next = ST_MUL;
                else if (last_axis)
                    state_next = ST_OUT;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_WIDEN;
                end
            end
            ST_MUL:
            begin
                prod_next = mag_s * mag_span;
                neg_next  = s_below ^ span_neg;
                quo_next  = '0;
                // zero range maps to the start value
                state_next = (range_w == '0) ? ST_FIX : ST_SAT;
            end
            ST_SAT:
            begin
                // any quotient past QUO_W bits clamps the same way
                if ({1'b0, prod_reg} >= sat_lim)
                begin
                    quo_next   = '1;
                    state_next = ST_FIX;
                end
                else
                begin
                    rem_next   = prod_reg;
                    dsh_next   = PROD_W'({range_w, {(QUO_W - 1){1'b0}}});
                    cnt_next   = CNT_W'(QUO_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                chan_next[axis_reg] = clamped;
                if (last_axis)
                    state_next = ST_OUT;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_WIDEN;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    o_chv_next      = (func_reg == FUNC_FLY);
                    o_chan_next     = chan_reg;
                    o_sw_next       = (func_reg == FUNC_FLY) ? sw_map : '0;
                    o_menu_next     = menu_reg;
                    o_changed_next  = changed_reg;
                    o_centered_next = centered_reg;
                    o_up_next       = up_reg;
                    o_down_next     = down_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            invert_reg    <= INVERT_RST;
            chlow_reg     <= CHAN_LOW_RST;
            chhigh_reg    <= CHAN_HIGH_RST;
            for (int a = 0; a < AXES; a++)
            begin
                low_reg[a]  <= RESET_POINT;
                high_reg[a] <= RESET_POINT;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            invert_reg    <= invert_next;
            chlow_reg     <= chlow_next;
            chhigh_reg    <= chhigh_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        smp_reg        <= smp_next;
        sw_reg         <= sw_next;
        menu_reg       <= menu_next;
        third_reg      <= third_next;
        changed_reg    <= changed_next;
        centered_reg   <= centered_next;
        up_reg         <= up_next;
        down_reg       <= down_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        rem_reg        <= rem_next;
        dsh_reg        <= dsh_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        chan_reg       <= chan_next;
        o_chv_reg      <= o_chv_next;
        o_chan_reg     <= o_chan_next;
        o_sw_reg       <= o_sw_next;
        o_menu_reg     <= o_menu_next;
        o_changed_reg  <= o_changed_next;
        o_centered_reg <= o_centered_next;
        o_up_reg       <= o_up_next;
        o_down_reg     <= o_down_next;
    end

    assign out_valid        = out_valid_reg;
    assign channels_valid   = o_chv_reg;
    assign throttle_channel = o_chan_reg[0];
    assign yaw_channel      = o_chan_reg[1];
    assign roll_channel     = o_chan_reg[2];
    assign pitch_channel    = o_chan_reg[3];
    assign switch_high_mask = o_sw_reg;
    assign menu_pressed     = o_menu_reg;
    assign range_changed    = o_changed_reg;
    assign sticks_centered  = o_centered_reg;
    assign up_flags         = o_up_reg;
    assign down_flags       = o_down_reg;

    // widening only lowers low or raises high, so every range stays ordered
    a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg[0] <= high_reg[0] && low_reg[1] <= high_reg[1] &&
        low_reg[2] <= high_reg[2] && low_reg[3] <= high_reg[3])
        else $error("axis low above axis high");

    a_chan_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && channels_valid |->
            throttle_channel >= floor_v && throttle_channel <= ceil_v &&
            pitch_channel >= floor_v && pitch_channel <= ceil_v)
        else $error("mapped channel outside channel range");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !channels_valid |->
            yaw_channel == '0 && roll_channel == '0 && switch_high_mask == '0)
        else $error("channel fields nonzero outside fly");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && !out_valid_reg |=> out_valid && state_reg == ST_IDLE)
        else $error("finished item not moved to output register");

endmodule
